>>> hw/rtl/ssp_pkg.sv
// Shared types and constants for the servo speed pulse mapper.
package ssp_pkg;

   localparam int PULSE_W    = 12;
   localparam int SPEED_W    = 8;
   localparam int REQ_W      = 16;
   localparam int MAG_W      = 7;
   localparam int OUTCOME_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int DIVIDEND_W = 19;
   localparam int DIVISOR_W  = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REV    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 2'd3;

   localparam logic [OUTCOME_W-1:0] OUTCOME_APPLIED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_IGNORED = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_RANGE   = 2'd2;

   localparam logic [PULSE_W-1:0] STOP_RESET = 12'd1500;
   localparam logic [PULSE_W-1:0] FWD_RESET  = 12'd2000;
   localparam logic [PULSE_W-1:0] REV_RESET  = 12'd1000;
   localparam logic [PULSE_W-1:0] PULSE_MAX  = 12'd4095;

   localparam logic [REQ_W-1:0] RAW_MIN = 16'd1000;
   localparam logic [REQ_W-1:0] RAW_MAX = 16'd2000;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 8'sd100;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -8'sd100;
   localparam logic signed [SPEED_W:0]   MIN_CHANGE = 9'sd3;
   localparam logic [MAG_W-1:0]          PERCENT    = 7'd100;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/ssp_ifs.sv
// Valid/ready channel interfaces for command and result items.
interface ssp_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic signed [ssp_pkg::REQ_W-1:0] speed_request;
   logic [ssp_pkg::REQ_W-1:0]        raw_pulse_us;

   modport source (output valid, operation, speed_request, raw_pulse_us, input ready);
   modport sink   (input valid, operation, speed_request, raw_pulse_us, output ready);
endinterface

interface ssp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ssp_pkg::PULSE_W-1:0]        pulse_out_us;
   logic [ssp_pkg::OUTCOME_W-1:0]      outcome;
   logic signed [ssp_pkg::SPEED_W-1:0] speed_now;

   modport source (output valid, pulse_out_us, outcome, speed_now, input ready);
   modport sink   (input valid, pulse_out_us, outcome, speed_now, output ready);
endinterface

>>> hw/rtl/ssp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ssp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ssp_pkg::div_req_type div_req,
   output ssp_pkg::div_rsp_type div_rsp
);
   import ssp_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;
   logic                  qbit;

   always_comb begin
      shifted    = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial      = {1'b0, shifted} - {2'b00, divisor_ff};
      qbit       = ~trial[DIVISOR_W+1];
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
         cnt_in     = CNT_W'(DIVIDEND_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> hw/rtl/servo_speed_pulse_mapper_top.sv
// Top level: servo speed/raw pulse command mapper with shared multiply and divider.
//
//  channel   | dir | handshake         | payload
//  req_chan  | in  | valid/ready       | operation, speed_request, raw_pulse_us
//  rsp_chan  | out | valid/ready       | pulse_out_us, outcome, speed_now
//  csr_*     | in  | csr_we, no stall  | csr_index, csr_wdata
//
// Mapped items pass from accept through ST_MUL, which multiplies and starts the
// bit-serial divider, then ST_DIV and ST_RESP; ignored, out-of-range and trivial
// items go straight to ST_RESP. One item at a time; req_chan.ready is low while an
// item is in work or its result cannot yet be loaded. The result register holds
// until taken. Reset is synchronous and restores register defaults and held state.
module servo_speed_pulse_mapper_top (
   input  logic                              clock,
   input  logic                              reset,
   ssp_req_if.sink                           req_chan,
   ssp_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [ssp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_RESP} state_type;
   typedef enum logic {MODE_MAP, MODE_EST} mode_type;

   state_type                   state_ff, state_in;
   mode_type                    mode_ff, mode_in;
   logic [PULSE_W-1:0]          stop_ff, fwd_ff, rev_ff;
   logic                        invert_ff;
   logic signed [SPEED_W-1:0]   speed_held_ff, speed_held_in;
   logic [PULSE_W-1:0]          pulse_held_ff, pulse_held_in;
   logic [OUTCOME_W-1:0]        outcome_ff, outcome_in;
   logic                        neg_ff, neg_in;
   logic [PULSE_W-1:0]          mul_a_ff, mul_a_in;
   logic [MAG_W-1:0]            mul_b_ff, mul_b_in;
   logic [DIVISOR_W-1:0]        divisor_ff, divisor_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]          rsp_pulse_ff, rsp_pulse_in;
   logic [OUTCOME_W-1:0]        rsp_outcome_ff, rsp_outcome_in;
   logic signed [SPEED_W-1:0]   rsp_speed_ff, rsp_speed_in;

   logic signed [REQ_W:0]       spd_ext, spd_dir;
   logic signed [SPEED_W-1:0]   spd_clamp, spd_abs;
   logic signed [SPEED_W:0]     spd_diff;
   logic                        small_change;
   logic signed [PULSE_W:0]     map_span, raw_off, est_span;
   logic                        raw_below, raw_in_range;
   logic [DIVIDEND_W-1:0]       quo;
   logic signed [PULSE_W+1:0]   map_sum;
   logic [PULSE_W-1:0]          map_pulse;
   logic [MAG_W-1:0]            est_mag;
   logic signed [SPEED_W-1:0]   est_speed;

   div_req_type                 div_req;
   div_rsp_type                 div_rsp;

   function automatic logic [PULSE_W-1:0] span_abs(input logic signed [PULSE_W:0] v);
      logic signed [PULSE_W:0] m;
      m = v[PULSE_W] ? -v : v;
      return m[PULSE_W-1:0];
   endfunction

   ssp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff   <= STOP_RESET;
         fwd_ff    <= FWD_RESET;
         rev_ff    <= REV_RESET;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STOP:   stop_ff   <= csr_wdata;
            CSR_FWD:    fwd_ff    <= csr_wdata;
            CSR_REV:    rev_ff    <= csr_wdata;
            CSR_INVERT: invert_ff <= csr_wdata[0];
         endcase
      end
   end

   // speed command front end
   always_comb begin
      spd_ext = {req_chan.speed_request[REQ_W-1], req_chan.speed_request};
      spd_dir = invert_ff ? -spd_ext : spd_ext;
      if (spd_dir > (REQ_W+1)'(SPEED_MAX)) begin
         spd_clamp = SPEED_MAX;
      end else if (spd_dir < (REQ_W+1)'(SPEED_MIN)) begin
         spd_clamp = SPEED_MIN;
      end else begin
         spd_clamp = spd_dir[SPEED_W-1:0];
      end
      spd_abs      = spd_clamp[SPEED_W-1] ? -spd_clamp : spd_clamp;
      spd_diff     = {spd_clamp[SPEED_W-1], spd_clamp}
                   - {speed_held_ff[SPEED_W-1], speed_held_ff};
      small_change = (spd_diff < MIN_CHANGE) && (spd_diff > -MIN_CHANGE);
      map_span     = spd_clamp[SPEED_W-1] ? ({1'b0, rev_ff} - {1'b0, stop_ff})
                                          : ({1'b0, fwd_ff} - {1'b0, stop_ff});
   end

   // raw command front end
   always_comb begin
      raw_in_range = (req_chan.raw_pulse_us >= RAW_MIN) && (req_chan.raw_pulse_us <= RAW_MAX);
      raw_off      = {1'b0, req_chan.raw_pulse_us[PULSE_W-1:0]} - {1'b0, stop_ff};
      raw_below    = raw_off[PULSE_W];
      est_span     = raw_below ? ({1'b0, stop_ff} - {1'b0, rev_ff})
                               : ({1'b0, fwd_ff} - {1'b0, stop_ff});
   end

   // quotient post-processing
   always_comb begin
      quo     = div_rsp.quotient;
      map_sum = {2'b00, stop_ff}
              + (neg_ff ? -{2'b00, quo[PULSE_W-1:0]} : {2'b00, quo[PULSE_W-1:0]});
      if (map_sum[PULSE_W+1]) begin
         map_pulse = '0;
      end else if (map_sum[PULSE_W]) begin
         map_pulse = PULSE_MAX;
      end else begin
         map_pulse = map_sum[PULSE_W-1:0];
      end
      est_mag   = (quo > DIVIDEND_W'(PERCENT)) ? PERCENT : quo[MAG_W-1:0];
      est_speed = neg_ff ? -{1'b0, est_mag} : {1'b0, est_mag};
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      speed_held_in  = speed_held_ff;
      pulse_held_in  = pulse_held_ff;
      outcome_in     = outcome_ff;
      neg_in         = neg_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      divisor_in     = divisor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_speed_in   = rsp_speed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               outcome_in = OUTCOME_APPLIED;
               state_in   = ST_RESP;
               if (!req_chan.operation) begin
                  if (small_change) begin
                     outcome_in = OUTCOME_IGNORED;
                  end else begin
                     speed_held_in = spd_clamp;
                     if (spd_clamp == '0) begin
                        pulse_held_in = stop_ff;
                     end else begin
                        mode_in    = MODE_MAP;
                        neg_in     = map_span[PULSE_W];
                        mul_a_in   = span_abs(map_span);
                        mul_b_in   = spd_abs[MAG_W-1:0];
                        divisor_in = DIVISOR_W'(PERCENT);
                        state_in   = ST_MUL;
                     end
                  end
               end else if (!raw_in_range) begin
                  outcome_in = OUTCOME_RANGE;
               end else begin
                  pulse_held_in = req_chan.raw_pulse_us[PULSE_W-1:0];
                  if (raw_off == '0 || est_span == '0) begin
                     speed_held_in = '0;
                  end else begin
                     mode_in    = MODE_EST;
                     neg_in     = est_span[PULSE_W] ^ raw_below;
                     mul_a_in   = span_abs(raw_off);
                     mul_b_in   = PERCENT;
                     divisor_in = span_abs(est_span);
                     state_in   = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (mode_ff == MODE_MAP) begin
                  pulse_held_in = map_pulse;
               end else begin
                  speed_held_in = est_speed;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pulse_in   = pulse_held_ff;
               rsp_outcome_in = outcome_ff;
               rsp_speed_in   = speed_held_ff;
               state_in       = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         speed_held_ff <= '0;
         pulse_held_ff <= STOP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         speed_held_ff <= speed_held_in;
         pulse_held_ff <= pulse_held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      outcome_ff     <= outcome_in;
      neg_ff         <= neg_in;
      mul_a_ff       <= mul_a_in;
      mul_b_ff       <= mul_b_in;
      divisor_ff     <= divisor_in;
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_speed_ff   <= rsp_speed_in;
   end

   assign div_req.start    = (state_ff == ST_MUL);
   assign div_req.dividend = DIVIDEND_W'(mul_a_ff) * DIVIDEND_W'(mul_b_ff);
   assign div_req.divisor  = divisor_ff;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pulse_out_us = rsp_pulse_ff;
   assign rsp_chan.outcome      = rsp_outcome_ff;
   assign rsp_chan.speed_now    = rsp_speed_ff;

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("new item accepted while previous item in work");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.speed_now <= SPEED_MAX && rsp_chan.speed_now >= SPEED_MIN))
      else $error("reported speed outside -100..100");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide phase");
`endif

endmodule
